// File: rtl/bba_pkg.sv
// Shared constants, codes and types of the buddy block allocator.
package bba_pkg;

    localparam int TOP_CLASS    = 16;
    localparam int MIN_CLASS    = 6;
    localparam int HEADER_BYTES = 8;
    localparam int LEVELS       = TOP_CLASS - MIN_CLASS + 1;
    localparam int NODE_COUNT   = (1 << LEVELS) - 1;
    localparam int IDX_W        = 11;
    localparam int DEPTH_W      = $clog2(LEVELS);
    localparam int CLS_W        = 5;
    localparam int SIZE_W       = 17;
    localparam int TOTAL_W      = 18;
    localparam int OFF_W        = 16;
    localparam int FLAG_W       = 2;

    localparam int FLAG_ALLOC = 0;
    localparam int FLAG_SPLIT = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic [SIZE_W-1:0] USABLE_RESET = 17'd65536;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_A_RD  = 11'b00000000100,
        S_A_EV  = 11'b00000001000,
        S_A_BT  = 11'b00000010000,
        S_A_UW  = 11'b00000100000,
        S_F_RD  = 11'b00001000000,
        S_F_EV  = 11'b00010000000,
        S_F_MEV = 11'b00100000000,
        S_F_PW  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

endpackage

// File: rtl/buddy_block_allocator.sv
// Buddy block allocator: a tree of node flags in one RAM, searched and merged in place.
//
// Requests are handled one at a time. After reset the block sweeps all 2047 tree nodes
// of the flag RAM to zero, one node a cycle, before it takes its first request. An
// allocate walks the tree left first, reading each node in turn and backtracking where
// a node is taken, then marks each ancestor of the granted node split. A free clears the
// block and merges it with its buddy, level by level, while the buddy is free. Requests
// rejected on size or index go straight to the result. The pace is set by the single
// read port of the flag RAM. A finished result waits in the output register while the
// next request is taken.
module buddy_block_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bba_pkg::SIZE_W-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [16:0] request_size, [27:17] free_index, [31:28] zero
    input  logic [31:0]                  s_axis_tdata,
    // [0] command
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [10:0] node_index, [26:11] block_offset, [42:27] user_offset, [47:43] zero
    output logic [47:0]                  m_axis_tdata,
    // [1:0] status
    output logic [1:0]                   m_axis_tuser
);
    import bba_pkg::*;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_cur, n_cur;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [DEPTH_W-1:0]   r_want, n_want;
    logic [IDX_W-1:0]     r_grant, n_grant;
    logic [SIZE_W-1:0]    r_usable;
    logic [1:0]           r_st, n_st;
    logic [IDX_W-1:0]     r_node, n_node;
    logic [OFF_W-1:0]     r_boff, n_boff;
    logic [OFF_W-1:0]     r_uoff, n_uoff;
    logic                 r_ovalid;
    logic [1:0]           r_ost;
    logic [IDX_W-1:0]     r_onode;
    logic [OFF_W-1:0]     r_oboff, r_ouoff;

    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [FLAG_W-1:0]    wdata, rdata;

    logic                 in_cmd;
    logic [SIZE_W-1:0]    in_size;
    logic [IDX_W-1:0]     in_idx;
    logic [TOTAL_W-1:0]   total;
    logic [CLS_W-1:0]     bitlen, cls;
    logic [IDX_W-1:0]     parent, mate, first, rel;
    logic [31:0]          off_wide;
    logic [CLS_W-1:0]     grant_cls;

    assign in_cmd  = s_axis_tuser;
    assign in_size = s_axis_tdata[16:0];
    assign in_idx  = s_axis_tdata[27:17];
    assign total   = {1'b0, in_size} + TOTAL_W'(HEADER_BYTES);

    always_comb begin
        bitlen = '0;
        for (int b = 0; b < TOTAL_W; b++) begin
            if (total[b]) begin
                bitlen = CLS_W'(b + 1);
            end
        end
        cls = (bitlen < CLS_W'(MIN_CLASS)) ? CLS_W'(MIN_CLASS) : bitlen;
    end

    assign parent = (r_cur - IDX_W'(1)) >> 1;
    assign mate   = r_cur[0] ? r_cur + IDX_W'(1) : r_cur - IDX_W'(1);

    // Offset of the granted block: its position within its level, scaled by its size.
    assign grant_cls = CLS_W'(TOP_CLASS) - CLS_W'(r_want);
    assign first     = (IDX_W'(1) << r_want) - IDX_W'(1);
    assign rel       = r_grant - first;
    assign off_wide  = {21'd0, rel} << grant_cls;

    bba_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (1 << IDX_W)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_depth = r_depth;
        n_want  = r_want;
        n_grant = r_grant;
        n_st    = r_st;
        n_node  = r_node;
        n_boff  = r_boff;
        n_uoff  = r_uoff;
        we      = 1'b0;
        waddr   = r_cur;
        wdata   = '0;
        raddr   = r_cur;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                n_cur = r_cur + IDX_W'(1);
                if (r_cur == IDX_W'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_st   = ST_OK;
                n_node = '0;
                n_boff = '0;
                n_uoff = '0;
                if (s_axis_tvalid) begin
                    if (in_cmd == CMD_ALLOC) begin
                        n_cur   = '0;
                        n_depth = '0;
                        n_want  = DEPTH_W'(CLS_W'(TOP_CLASS) - cls);
                        if (in_size == '0 || total > {1'b0, r_usable}
                            || cls > CLS_W'(TOP_CLASS)) begin
                            n_st    = ST_BAD_SIZE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        n_cur = in_idx;
                        if (in_idx >= IDX_W'(NODE_COUNT)) begin
                            n_st    = ST_IGNORED;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (rdata[FLAG_ALLOC]) begin
                    n_state = S_A_BT;
                end else if (r_depth == r_want) begin
                    if (rdata[FLAG_SPLIT]) begin
                        n_state = S_A_BT;
                    end else begin
                        we      = 1'b1;
                        wdata   = rdata | FLAG_W'(1 << FLAG_ALLOC);
                        n_grant = r_cur;
                        if (r_cur == '0) begin
                            // The whole region is granted at offset zero.
                            n_uoff  = OFF_W'(HEADER_BYTES);
                            n_state = S_DONE;
                        end else begin
                            raddr   = parent;
                            n_cur   = parent;
                            n_state = S_A_UW;
                        end
                    end
                end else begin
                    // Descend into the left half and read it right away.
                    n_cur   = {r_cur[IDX_W-2:0], 1'b1};
                    n_depth = r_depth + DEPTH_W'(1);
                    raddr   = n_cur;
                end
            end
            S_A_BT: begin
                if (r_cur == '0) begin
                    n_st    = ST_NO_SPACE;
                    n_state = S_DONE;
                end else if (r_cur[0]) begin
                    n_cur   = r_cur + IDX_W'(1);
                    raddr   = n_cur;
                    n_state = S_A_EV;
                end else begin
                    n_cur   = parent;
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            S_A_UW: begin
                we    = 1'b1;
                wdata = rdata | FLAG_W'(1 << FLAG_SPLIT);
                if (r_cur == '0) begin
                    n_node  = r_grant;
                    n_boff  = off_wide[OFF_W-1:0];
                    n_uoff  = off_wide[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
                    n_state = S_DONE;
                end else begin
                    raddr = parent;
                    n_cur = parent;
                end
            end
            S_F_RD: begin
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (!rdata[FLAG_ALLOC]) begin
                    n_st    = ST_IGNORED;
                    n_state = S_DONE;
                end else begin
                    we    = 1'b1;
                    wdata = rdata & ~FLAG_W'(1 << FLAG_ALLOC);
                    if (r_cur == '0) begin
                        n_state = S_DONE;
                    end else begin
                        raddr   = mate;
                        n_state = S_F_MEV;
                    end
                end
            end
            S_F_MEV: begin
                if (rdata != '0) begin
                    n_state = S_DONE;
                end else begin
                    raddr   = parent;
                    n_cur   = parent;
                    n_state = S_F_PW;
                end
            end
            S_F_PW: begin
                // The parent loses its split flag and, as the merged block, is free.
                we    = 1'b1;
                wdata = rdata & ~FLAG_W'((1 << FLAG_SPLIT) | (1 << FLAG_ALLOC));
                if (r_cur == '0) begin
                    n_state = S_DONE;
                end else begin
                    raddr   = mate;
                    n_state = S_F_MEV;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cur    <= '0;
            r_usable <= USABLE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            if (i_cfg_we) begin
                r_usable <= i_cfg_wdata;
            end
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_depth <= n_depth;
        r_want  <= n_want;
        r_grant <= n_grant;
        r_st    <= n_st;
        r_node  <= n_node;
        r_boff  <= n_boff;
        r_uoff  <= n_uoff;
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ost   <= r_st;
            r_onode <= r_node;
            r_oboff <= r_boff;
            r_ouoff <= r_uoff;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ouoff, r_oboff, r_onode};
    assign m_axis_tuser  = r_ost;
endmodule

// File: rtl/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
